// ===== hw/rtl/baudot_teleprinter_line_transceiver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Baudot line transceiver
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BAUDOT_TELEPRINTER_LINE_TRANSCEIVER_ASSERT_SVH
`define BAUDOT_TELEPRINTER_LINE_TRANSCEIVER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BTLT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BTLT_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/btlt_pkg.sv =====
// ----------------------------------------------------------------------------
// btlt_pkg
// Shared constants and word types of the Baudot line transceiver.
// ----------------------------------------------------------------------------
`default_nettype none

package btlt_pkg;

	localparam int DATA_BITS          = 5;
	localparam int BL_WIDTH           = 7;
	localparam int RX_TIMER_WIDTH_DEF = 10;

	localparam logic [BL_WIDTH-1:0] BIT_LENGTH_RESET = BL_WIDTH'(20);

	typedef struct packed {
		logic                 line_in;
		logic                 ms_tick;
		logic                 tx_load;
		logic [DATA_BITS-1:0] tx_char;
	} btlt_item_t;

	typedef struct packed {
		logic                 line_out;
		logic                 tx_busy;
		logic                 rx_done;
		logic [DATA_BITS-1:0] rx_char;
		logic                 rx_stop_error;
	} btlt_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/btlt_core.sv =====
// ----------------------------------------------------------------------------
// btlt_core
// Transmit and receive state of the line transceiver, advanced by one input
// word whenever advance is high. The result is the state after that word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "baudot_teleprinter_line_transceiver_assert.svh"

module btlt_core #(
	parameter int RX_TIMER_WIDTH = btlt_pkg::RX_TIMER_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           advance,
	input  wire btlt_pkg::btlt_item_t           item,
	input  wire logic [btlt_pkg::BL_WIDTH-1:0]  bit_len,
	output btlt_pkg::btlt_result_t              result
);
	import btlt_pkg::*;

	localparam int TxTw   = 9;
	localparam int CW     = ((RX_TIMER_WIDTH > TxTw) ? RX_TIMER_WIDTH : TxTw) + 1;
	localparam int IdxW   = $clog2(DATA_BITS + 1);
	localparam int FrameW = DATA_BITS + 3;

	localparam logic [RX_TIMER_WIDTH-1:0] RxTmax = '1;
	localparam logic [TxTw-1:0]           TxTmax = '1;
	localparam logic [7:0] LevelMid    = 8'd128;
	localparam logic [7:0] LevelReject = 8'd150;
	localparam logic [7:0] LevelMax    = 8'd255;
	localparam logic [IdxW-1:0] LastData = IdxW'(DATA_BITS - 1);
	localparam logic [IdxW-1:0] LastShift = IdxW'(DATA_BITS);

	typedef enum logic [4:0] {
		RX_WAIT  = 5'b00001,
		RX_START = 5'b00010,
		RX_DATA  = 5'b00100,
		RX_STOP  = 5'b01000,
		RX_DONE  = 5'b10000
	} rx_state_t;

	typedef enum logic [3:0] {
		TX_IDLE   = 4'b0001,
		TX_LOADED = 4'b0010,
		TX_SHIFT  = 4'b0100,
		TX_STOP   = 4'b1000
	} tx_state_t;

	rx_state_t                 rx_state_q, rx_state_n;
	logic [IdxW-1:0]           rx_idx_q, rx_idx_n;
	logic [DATA_BITS-1:0]      rx_shift_q, rx_shift_n;
	logic                      rx_err_q, rx_err_n;
	logic [7:0]                level_q, level_n;
	logic [RX_TIMER_WIDTH-1:0] rx_el_q, rx_el_n;
	tx_state_t                 tx_state_q, tx_state_n;
	logic [IdxW-1:0]           tx_cnt_q, tx_cnt_n;
	logic [FrameW-1:0]         tx_shift_q, tx_shift_n;
	logic [TxTw-1:0]           tx_el_q, tx_el_n;
	logic                      line_out_q, line_out_n;

	function automatic logic [7:0] level_step(input logic [7:0] lc, input logic mark);
		logic [7:0] r;
		r = lc;
		if (mark) begin
			if (lc != LevelMax) r = lc + 8'd1;
		end else begin
			if (lc != 8'd0) r = lc - 8'd1;
		end
		return r;
	endfunction

	always_comb begin
		logic [CW-1:0]             bl_w, bl3, bl_half, half_amt, rt, tt;
		logic [RX_TIMER_WIDTH-1:0] rx_el_t;
		logic [TxTw-1:0]           tx_el_t;
		logic [7:0]                lc_up;
		logic                      rx_free;

		bl_w     = CW'(bit_len);
		bl3      = bl_w + (bl_w << 1);
		bl_half  = bl_w >> 1;
		half_amt = (bl_half >= CW'(2)) ? (bl_half - CW'(2)) : '0;

		// Both timers count milliseconds first, saturating.
		rx_el_t = rx_el_q;
		tx_el_t = tx_el_q;
		if (item.ms_tick) begin
			if (rx_el_q != RxTmax) rx_el_t = rx_el_q + 1'b1;
			if (tx_el_q != TxTmax) tx_el_t = tx_el_q + 1'b1;
		end
		rt    = CW'(rx_el_t);
		tt    = CW'(tx_el_t);
		lc_up = level_step(level_q, item.line_in);

		tx_state_n = tx_state_q;
		tx_cnt_n   = tx_cnt_q;
		tx_shift_n = tx_shift_q;
		tx_el_n    = tx_el_t;
		line_out_n = line_out_q;
		if (item.tx_load && tx_state_q == TX_IDLE) begin
			tx_state_n = TX_LOADED;
			tx_shift_n = FrameW'(item.tx_char);
		end

		// Transmitter: wait for a quiet receiver, then start, data, 1.5-bit stop.
		rx_free = (rx_state_q == RX_WAIT) || (rx_state_q == RX_DONE);
		case (tx_state_n)
			TX_IDLE: begin
			end
			TX_LOADED: begin
				if (rx_free && rt >= bl3) begin
					line_out_n = 1'b0;
					tx_el_n    = '0;
					tx_state_n = TX_SHIFT;
					tx_cnt_n   = '0;
					tx_shift_n = {1'b0, tx_shift_n[DATA_BITS-1:0], 2'b11};
				end
			end
			TX_SHIFT: begin
				line_out_n = tx_shift_n[FrameW-1];
				if (tt >= bl_w) begin
					tx_el_n    = TxTw'(tt - bl_w);
					tx_shift_n = tx_shift_n << 1;
					if (tx_cnt_n == LastShift) begin
						tx_state_n = TX_STOP;
					end else begin
						tx_cnt_n = tx_cnt_n + 1'b1;
					end
				end
			end
			TX_STOP: begin
				line_out_n = 1'b1;
				if (tt >= (bl3 >> 1)) begin
					tx_el_n    = '0;
					tx_state_n = TX_IDLE;
				end
			end
			default: tx_state_n = TX_IDLE;
		endcase

		rx_state_n = rx_state_q;
		rx_idx_n   = rx_idx_q;
		rx_shift_n = rx_shift_q;
		rx_err_n   = rx_err_q;
		level_n    = level_q;
		rx_el_n    = rx_el_t;
		case (rx_state_q)
			RX_WAIT, RX_DONE: begin
				// A finished character is held for a few ms before a new start.
				if ((rx_state_q == RX_WAIT || rt > CW'(2)) && !item.line_in) begin
					rx_el_n    = '0;
					rx_state_n = RX_START;
					rx_shift_n = '0;
					level_n    = LevelMid;
					rx_err_n   = 1'b0;
				end
			end
			RX_START: begin
				level_n = lc_up;
				if (lc_up > LevelReject) begin
					rx_state_n = RX_WAIT;
				end else if (rt > bl_half) begin
					if (lc_up < LevelMid) begin
						rx_state_n = RX_DATA;
						rx_idx_n   = '0;
						level_n    = LevelMid;
						rx_el_n    = (rt >= half_amt) ? RX_TIMER_WIDTH'(rt - half_amt) : '0;
					end else begin
						rx_state_n = RX_WAIT;
					end
				end
			end
			RX_DATA: begin
				// Majority over the last 4 ms of the bit.
				if (rt + CW'(4) >= bl_w) begin
					level_n = lc_up;
					if (rt >= bl_w) begin
						rx_shift_n = {rx_shift_q[DATA_BITS-2:0], lc_up[7]};
						rx_el_n    = RX_TIMER_WIDTH'(rt - bl_w);
						level_n    = LevelMid;
						if (rx_idx_q == LastData) begin
							rx_state_n = RX_STOP;
						end else begin
							rx_idx_n = rx_idx_q + 1'b1;
						end
					end
				end
			end
			RX_STOP: begin
				if (rt + CW'(4) >= bl_w) begin
					level_n = lc_up;
					if (rt >= (bl3 >> 2) && item.line_in) begin
						rx_err_n   = ~lc_up[7];
						rx_state_n = RX_DONE;
						rx_el_n    = '0;
					end
				end
			end
			default: rx_state_n = RX_WAIT;
		endcase

		result.line_out      = line_out_n;
		result.tx_busy       = (tx_state_n != TX_IDLE);
		result.rx_done       = (rx_state_n == RX_DONE);
		result.rx_char       = rx_shift_n;
		result.rx_stop_error = rx_err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q <= RX_WAIT;
			rx_idx_q   <= '0;
			rx_shift_q <= '0;
			rx_err_q   <= 1'b0;
			level_q    <= LevelMid;
			rx_el_q    <= RxTmax;
			tx_state_q <= TX_IDLE;
			tx_cnt_q   <= '0;
			tx_shift_q <= '0;
			tx_el_q    <= '0;
			line_out_q <= 1'b1;
		end else if (advance) begin
			rx_state_q <= rx_state_n;
			rx_idx_q   <= rx_idx_n;
			rx_shift_q <= rx_shift_n;
			rx_err_q   <= rx_err_n;
			level_q    <= level_n;
			rx_el_q    <= rx_el_n;
			tx_state_q <= tx_state_n;
			tx_cnt_q   <= tx_cnt_n;
			tx_shift_q <= tx_shift_n;
			tx_el_q    <= tx_el_n;
			line_out_q <= line_out_n;
		end
	end

	`BTLT_ASSERT_ALWAYS(a_rx_idx_range, rx_idx_q <= LastData, "receive bit index out of range")
	`BTLT_ASSERT_ALWAYS(a_tx_cnt_range, tx_cnt_q <= LastShift, "transmit bit count out of range")
	`BTLT_ASSERT_NEXT(a_hold_no_adv, !advance,
		$stable(rx_state_q) && $stable(tx_state_q) && $stable(level_q),
		"state changed without an input word")
	`BTLT_ASSERT_ALWAYS(a_idle_line_mark, tx_state_q != TX_IDLE || line_out_q,
		"idle transmitter drives space")

endmodule

`default_nettype wire

// ===== hw/rtl/baudot_teleprinter_line_transceiver.sv =====
// ----------------------------------------------------------------------------
// Baudot teleprinter line transceiver.
// Input stream s_*: one word per poll of the line, carrying the line sample,
// a millisecond strobe, a send request and the five-bit code to send.
// Output stream m_*: exactly one word per input word, giving the transmit
// line level, transmitter busy, receive-done, the received code and the
// stop-bit error flag as they stand after that input word.
// A word accepted into the input register is processed when the output register
// is free or being emptied, and its result word is then held in the output register.
// Throughput: one word per cycle while m_tready is high; the input register and
// the output register let a new word enter while a finished result waits to be taken.
// When m_tready is low the output register holds, the input register fills
// and s_tready falls; nothing is dropped or repeated.
// Reset (arst_n low) empties both registers, sets the line to mark, both
// sides idle, the receive timer saturated and the bit length to 20 ms.
// The APB port holds the bit length in ms at address 0; write it only while
// no words are in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "baudot_teleprinter_line_transceiver_assert.svh"

module baudot_teleprinter_line_transceiver #(
	parameter int RX_TIMER_WIDTH = btlt_pkg::RX_TIMER_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // line_in, ms_tick, tx_load, tx_char[4:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // line_out, tx_busy, rx_done, rx_char[4:0],
	                                    // rx_stop_error, zero fill
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import btlt_pkg::*;

	localparam logic RegBitLength = 1'b0;

	logic [BL_WIDTH-1:0] bit_len_q;
	btlt_item_t          item_s1;
	logic                valid_s1;
	btlt_result_t        result;
	btlt_result_t        result_q;
	logic                out_valid_q;
	logic                advance;
	logic                in_accept;
	logic                cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegBitLength);
	assign prdata    = (paddr[2] == RegBitLength) ? 32'(bit_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_len_q <= BIT_LENGTH_RESET;
		end else if (cfg_write) begin
			bit_len_q <= pwdata[BL_WIDTH-1:0];
		end
	end

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.line_in <= s_tdata[0];
			item_s1.ms_tick <= s_tdata[1];
			item_s1.tx_load <= s_tdata[2];
			item_s1.tx_char <= s_tdata[7:3];
		end
	end

	btlt_core #(
		.RX_TIMER_WIDTH(RX_TIMER_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.bit_len   (bit_len_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, result_q.rx_stop_error, result_q.rx_char, result_q.rx_done,
		result_q.tx_busy, result_q.line_out};

	`BTLT_ASSERT_NEXT(a_stalled_word_kept, valid_s1 && !advance, valid_s1,
		"pending input word lost while output stalled")
	`BTLT_ASSERT_NEXT(a_result_follows, advance, out_valid_q,
		"processed word produced no result")
	`BTLT_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"result word changed while stalled")

endmodule

`default_nettype wire
